[sv/dfmt_pkg.sv]
`default_nettype none
package dfmt_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int DIG_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic [1:0] OP_SIGNED   = 2'd0;
  localparam logic [1:0] OP_UNSIGNED = 2'd1;
  localparam logic [1:0] OP_MILLIVOLT = 2'd2;

  localparam logic [9:0]  ADC_MAX  = 10'd1023;
  localparam logic [12:0] MV_CORR  = 13'd18;
  localparam logic [31:0] RECIP_10 = 32'hCCCCCCCD;
  localparam int          RECIP_SH = 35;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] value;
  } fmt_req_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } fmt_char_t;

  function automatic logic [12:0] mv_threshold(input logic [1:0] idx);
    logic [12:0] t;
    case (idx)
      2'd0:    t = 13'd1000;
      2'd1:    t = 13'd2000;
      2'd2:    t = 13'd3000;
      2'd3:    t = 13'd4000;
      default: t = 13'd4000;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] suffix_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h6D;
      2'd1:    c = 8'h56;
      2'd2:    c = 8'h0A;
      2'd3:    c = 8'h0D;
      default: c = 8'h0D;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[sv/decimal_ascii_formatter.sv]
`default_nettype none
// channel  direction  payload     handshake
// src      in         fmt_req_t   src_valid / src_stall
// dst      out        fmt_char_t  dst_valid / dst_stall
//
// One request at a time. Millivolt mode first corrects the value against each
// of the four thresholds, then each decimal digit goes through the shared
// reciprocal multiplier (multiply, then quotient/remainder). Characters then
// leave one per cycle from the output register while dst_stall is low.
// Undefined operation returns to idle at once. Synchronous reset clears the
// sequencer and dst_valid.
module decimal_ascii_formatter (
  input  wire                  clk,
  input  wire                  rst,
  input  dfmt_pkg::fmt_req_t   src_data,
  input  wire                  src_valid,
  output logic                 src_stall,
  output dfmt_pkg::fmt_char_t  dst_data,
  output logic                 dst_valid,
  input  wire                  dst_stall
);
  import dfmt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CORR = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIG  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]       state;
  logic [31:0]      val;
  logic [63:0]      prod;
  logic [DIG_W-1:0] cnt;
  logic [1:0]       sidx;
  logic             minus;
  logic             mv_mode;
  logic             in_suffix;
  logic [7:0]       digits [MAX_DIGITS];

  logic        accept;
  logic        load_ok;
  logic [9:0]  sat;
  logic [12:0] mv6;
  logic [31:0] quo;
  logic [31:0] rem_full;
  logic [12:0] thr;

  assign src_stall = (state != S_IDLE);
  assign accept    = src_valid && !src_stall;
  assign load_ok   = !dst_valid || !dst_stall;

  always_comb begin
    sat      = (src_data.value > 32'(ADC_MAX)) ? ADC_MAX : src_data.value[9:0];
    mv6      = {1'b0, sat, 2'b00} + {2'b00, sat, 1'b0};
    quo      = 32'(prod[63:RECIP_SH]);
    rem_full = val - ((quo << 3) + (quo << 1));
    thr      = mv_threshold(sidx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dst_valid <= 1'b0;
    end else begin
      if (dst_valid && !dst_stall && state != S_EMIT) dst_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cnt       <= '0;
            sidx      <= 2'd0;
            in_suffix <= 1'b0;
            minus     <= (src_data.operation == OP_SIGNED) && src_data.value[31];
            mv_mode   <= (src_data.operation == OP_MILLIVOLT);
            case (src_data.operation)
              OP_SIGNED: begin
                val   <= src_data.value[31] ? (~src_data.value + 32'd1) : src_data.value;
                state <= S_MUL;
              end
              OP_UNSIGNED: begin
                val   <= src_data.value;
                state <= S_MUL;
              end
              OP_MILLIVOLT: begin
                val     <= 32'(mv6);
                state   <= S_CORR;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CORR: begin
          if (val > 32'(thr)) val <= val - 32'(MV_CORR);
          sidx <= sidx + 2'd1;
          if (sidx == 2'd3) state <= S_MUL;
        end
        S_MUL: begin
          prod  <= {32'b0, val} * {32'b0, RECIP_10};
          state <= S_DIG;
        end
        S_DIG: begin
          digits[cnt] <= CH_ZERO + {4'b0, rem_full[3:0]};
          val         <= quo;
          if (quo == 32'd0 || cnt == DIG_W'(MAX_DIGITS - 1)) begin
            sidx  <= 2'd0;
            state <= S_EMIT;
          end else begin
            cnt   <= cnt + DIG_W'(1);
            state <= S_MUL;
          end
        end
        S_EMIT: begin
          if (load_ok) begin
            dst_valid <= 1'b1;
            if (minus) begin
              dst_data.char_out <= CH_MINUS;
              dst_data.last     <= 1'b0;
              minus             <= 1'b0;
            end else if (!in_suffix) begin
              dst_data.char_out <= digits[cnt];
              dst_data.last     <= (cnt == '0) && !mv_mode;
              if (cnt == '0) begin
                if (mv_mode) in_suffix <= 1'b1;
                else state <= S_IDLE;
              end else begin
                cnt <= cnt - DIG_W'(1);
              end
            end else begin
              dst_data.char_out <= suffix_char(sidx);
              dst_data.last     <= (sidx == 2'd3);
              sidx              <= sidx + 2'd1;
              if (sidx == 2'd3) state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[test/ascii_text_checker.sv]
module ascii_text_checker (
  input  wire                  clk,
  input  wire                  rst,
  input  dfmt_pkg::fmt_req_t   src_data,
  input  wire                  src_valid,
  input  wire                  src_stall,
  input  dfmt_pkg::fmt_char_t  dst_data,
  input  wire                  dst_valid,
  input  wire                  dst_stall,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import dfmt_pkg::*;

  localparam logic [7:0]  CH_M     = 8'h6D;
  localparam logic [7:0]  CH_V     = 8'h56;
  localparam logic [7:0]  CH_LF    = 8'h0A;
  localparam logic [7:0]  CH_CR    = 8'h0D;
  localparam logic [31:0] MV_SCALE = 32'd6;
  localparam logic [31:0] MV_STEP  = 32'd1000;

  fmt_char_t text_due[$];
  int fails  = 0;
  int queued = 0;

  assign errors  = fails;
  assign pending = queued;

  function automatic void expect_text(fmt_req_t req);
    logic [31:0] num;
    logic [7:0]  text[$];
    string       digits;
    fmt_char_t   ch;
    num = req.value;
    case (req.operation)
      OP_SIGNED: begin
        if (req.value[31]) begin
          text.push_back(CH_MINUS);
          num = ~req.value + 32'd1;
        end
      end
      OP_UNSIGNED: ;
      OP_MILLIVOLT: begin
        num = (req.value > ADC_MAX) ? 32'(ADC_MAX) : req.value;
        num = num * MV_SCALE;
        // thresholds applied in order, each on the corrected value
        for (int k = 1; k <= 4; k++) begin
          if (num > MV_STEP * k) num = num - 32'(MV_CORR);
        end
      end
      default: return;
    endcase
    digits = $sformatf("%0d", num);
    foreach (digits[i]) text.push_back(digits[i]);
    if (req.operation == OP_MILLIVOLT) begin
      text.push_back(CH_M);
      text.push_back(CH_V);
      text.push_back(CH_LF);
      text.push_back(CH_CR);
    end
    foreach (text[i]) begin
      ch.char_out = text[i];
      ch.last     = (i == text.size() - 1);
      text_due.push_back(ch);
    end
  endfunction

  task automatic report(input string what);
    if (fails < 200) $display("checker: %0t %s", $realtime, what);
    fails++;
  endtask

  always @(posedge clk) begin
    fmt_char_t want;
    if (!rst) begin
      if (src_valid && !src_stall) expect_text(src_data);
      if (dst_valid && !dst_stall) begin
        if (text_due.size() == 0) begin
          report($sformatf("unexpected char %02h last %0b", dst_data.char_out,
                           dst_data.last));
        end else begin
          want = text_due.pop_front();
          if (dst_data.char_out !== want.char_out)
            report($sformatf("char_out %02h, expected %02h", dst_data.char_out,
                             want.char_out));
          if (dst_data.last !== want.last)
            report($sformatf("last %0b, expected %0b on char %02h", dst_data.last,
                             want.last, want.char_out));
        end
      end
    end
    queued = text_due.size();
  end

endmodule

[test/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dfmt_pkg::*;

  localparam logic [1:0] OP_UNDEF     = 2'd3;
  localparam int         RANDOM_REQS  = 290;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         HOLD_AFTER   = 120;
  localparam int         IDLE_LIMIT   = 3000;
  localparam int         DRAIN_CYCLES = 48;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_mode_e;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  fmt_req_t  src_data  = '0;
  logic      src_valid = 1'b0;
  logic      src_stall;
  fmt_char_t dst_data;
  logic      dst_valid;
  logic      dst_stall = 1'b0;

  int errors;
  int pending;
  int sent        = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  bit holding     = 1'b0;
  bit hold_done   = 1'b0;

  always #4 clk = ~clk;

  decimal_ascii_formatter dut (
    .clk       (clk),
    .rst       (rst),
    .src_data  (src_data),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .dst_data  (dst_data),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall)
  );

  ascii_text_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .src_data  (src_data),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .dst_data  (dst_data),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .errors    (errors),
    .pending   (pending)
  );

  always @(posedge clk) begin
    if (rst || (src_valid && !src_stall) || (dst_valid && !dst_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // receiver: changing stall patterns, one long hold-off once traffic is flowing
  initial begin
    rx_mode_e mode;
    int       span;
    int       tick;
    tick = 0;
    forever begin
      if (!hold_done && sent >= HOLD_AFTER) begin
        holding = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          dst_stall <= 1'b1;
        end
        holding   = 1'b0;
        hold_done = 1'b1;
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(8, 60);
      repeat (span) begin
        @(posedge clk);
        tick++;
        case (mode)
          RX_OPEN:     dst_stall <= 1'b0;
          RX_RANDOM:   dst_stall <= ($urandom_range(0, 1) == 1);
          RX_PERIODIC: dst_stall <= (tick % 3 == 0);
          default:     dst_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic issue(input logic [1:0] op, input logic [31:0] val);
    int gap;
    src_data  <= {op, val};
    src_valid <= 1'b1;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !holding) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      src_valid <= 1'b0;
      src_data  <= {2'($urandom_range(0, 3)), $urandom()};
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
    end
  endtask

  function automatic logic [31:0] pick_value(input logic [1:0] op);
    logic [31:0] val;
    int          sel;
    sel = $urandom_range(0, 9);
    if (op == OP_MILLIVOLT && sel < 7) begin
      val = $urandom_range(0, 1100);
    end else begin
      case (sel)
        0, 1: val = $urandom_range(0, 20);
        2, 3: begin
          val = 32'd1;
          repeat ($urandom_range(0, 9)) val = val * 32'd10;
          val = val + $urandom_range(0, 2) - 1;
          if ($urandom_range(0, 1) == 1) val = -val;
        end
        4: begin
          case ($urandom_range(0, 3))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7FFF_FFFF;
            2:       val = 32'hFFFF_FFFF;
            default: val = 32'h8000_0001;
          endcase
        end
        default: val = $urandom();
      endcase
    end
    return val;
  endfunction

  initial begin
    logic [1:0] op;
    int         pick;
    int         real_reqs;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue(OP_SIGNED, 32'd0);
    issue(OP_SIGNED, 32'd1);
    issue(OP_SIGNED, 32'hFFFF_FFFF);
    issue(OP_SIGNED, 32'h7FFF_FFFF);
    issue(OP_SIGNED, 32'h8000_0000);
    issue(OP_SIGNED, -32'd10);
    issue(OP_SIGNED, 32'd1000000000);
    issue(OP_UNSIGNED, 32'd0);
    issue(OP_UNSIGNED, 32'hFFFF_FFFF);
    issue(OP_UNSIGNED, 32'd9);
    issue(OP_UNSIGNED, 32'd10);
    issue(OP_UNSIGNED, 32'h8000_0000);
    issue(OP_MILLIVOLT, 32'd0);
    issue(OP_MILLIVOLT, 32'd1);
    issue(OP_MILLIVOLT, 32'd166);
    issue(OP_MILLIVOLT, 32'd167);
    issue(OP_MILLIVOLT, 32'd337);
    issue(OP_MILLIVOLT, 32'd503);
    issue(OP_MILLIVOLT, 32'd670);
    issue(OP_MILLIVOLT, 32'd1023);
    issue(OP_MILLIVOLT, 32'd1024);
    issue(OP_MILLIVOLT, 32'hFFFF_FFFF);
    issue(OP_UNDEF, 32'd0);
    issue(OP_UNDEF, 32'hFFFF_FFFF);

    real_reqs = 0;
    while (real_reqs < RANDOM_REQS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)       op = OP_UNDEF;
      else if (pick <= 6)  op = OP_SIGNED;
      else if (pick <= 12) op = OP_UNSIGNED;
      else                 op = OP_MILLIVOLT;
      issue(op, pick_value(op));
      if (op != OP_UNDEF) real_reqs++;
    end
    src_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
